FILE: rtl/cdda_pkg.sv
// Package for the Gregorian date register with day addition and comparison.
// Holds the request and result types, command codes and calendar helpers.
// No dependencies.
package cdda_pkg;

    localparam int YEAR_BITS_DEF = 16;
    localparam int DAYS_BITS_DEF = 16;

    localparam logic [1:0] CMD_LOAD    = 2'd0;
    localparam logic [1:0] CMD_ADD     = 2'd1;
    localparam logic [1:0] CMD_COMPARE = 2'd2;

    localparam int unsigned DAYS_PER_400Y = 146097;
    localparam logic [4:0]  FEB_LEAP_LEN  = 5'd29;
    localparam logic [3:0]  LAST_MONTH    = 4'd12;
    localparam logic [8:0]  YEARS_PER_ERA = 9'd400;

    localparam logic [4:0] MONTH_LEN [12] = '{
        5'd31, 5'd28, 5'd31, 5'd30, 5'd31, 5'd30,
        5'd31, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31
    };

    typedef struct packed {
        logic [1:0]  cmd;
        logic [4:0]  op_day;
        logic [3:0]  op_month;
        logic [15:0] op_year;
        logic [15:0] add_days;
    } cdda_req_t;

    typedef struct packed {
        logic [4:0]  cur_day;
        logic [3:0]  cur_month;
        logic [15:0] cur_year;
        logic        invalid;
        logic        earlier;
        logic        same;
    } cdda_rsp_t;

    // Leap test on the year taken modulo 400.
    function automatic logic is_leap(input logic [8:0] ymod);
        is_leap = (ymod[1:0] == 2'd0) && (ymod != 9'd100) && (ymod != 9'd200)
                  && (ymod != 9'd300);
    endfunction

    function automatic logic [4:0] days_in(input logic [3:0] month, input logic leap);
        logic [3:0] idx;
        idx = month - 4'd1;
        if (month == 4'd2 && leap) begin
            days_in = FEB_LEAP_LEN;
        end else if (month >= 4'd1 && month <= LAST_MONTH) begin
            days_in = MONTH_LEN[idx];
        end else begin
            days_in = 5'd31;
        end
    endfunction

endpackage

FILE: rtl/calendar_date_day_adder_top.sv
// Top level of the Gregorian date register with day addition and comparison.
// Depends on cdda_pkg for the request and result types and calendar helpers.
//
// Usage: requests arrive on s_valid/s_ready/s_data and results leave on
// m_valid/m_ready/m_data, one result per request. A load checks the operand
// date and stores it, an add advances the stored date by a number of days, and
// a compare reports whether the stored date is earlier than or equal to the
// operand. Every result carries the stored date after the request and flags.
// The block works on one request at a time and holds s_ready low meanwhile.
// A compare or an unused command goes from ST_IDLE to ST_DONE and then into the
// output register. A load passes ST_MOD, ST_REM and ST_LOAD: the operand year is
// reduced modulo 400 for the leap test by a reciprocal multiplication in ST_MOD
// and a subtraction in ST_REM. An add runs in ST_ADD, one step of the shared day
// subtractor at a time: one step per 400 years, per whole year from January 1, or
// per month, up to about 200 steps for the largest 16-bit count. The result waits
// in an output register while m_ready is low; the next request is accepted as
// soon as the previous one has reached it.
// Reset sets the stored date to January 1, 2000 and empties the output.
module calendar_date_day_adder_top
    import cdda_pkg::*;
#(
    parameter int YEAR_BITS = YEAR_BITS_DEF,
    parameter int DAYS_BITS = DAYS_BITS_DEF
) (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  cdda_req_t s_data,
    output logic      m_valid,
    input  logic      m_ready,
    output cdda_rsp_t m_data
);

    localparam int CW = (DAYS_BITS > 18) ? DAYS_BITS : 18;
    localparam logic [YEAR_BITS-1:0] YMAX = {YEAR_BITS{1'b1}};

    // The year divided by 400 is the year divided by 16, then by 25.
    localparam int QN = YEAR_BITS - 4;
    localparam int QS = QN + 5;
    localparam int QW = YEAR_BITS - 8;
    localparam longint QMUL = ((longint'(1) << QS) + 24) / 25;
    localparam logic [QN:0] QMAG = (QN+1)'(QMUL);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_MOD  = 3'd1;
    localparam logic [2:0] ST_LOAD = 3'd2;
    localparam logic [2:0] ST_ADD  = 3'd3;
    localparam logic [2:0] ST_DONE = 3'd4;
    localparam logic [2:0] ST_REM  = 3'd5;

    logic [2:0]           state_reg, state_next;
    logic [4:0]           day_reg, day_next;
    logic [3:0]           month_reg, month_next;
    logic [YEAR_BITS-1:0] year_reg, year_next;
    logic [8:0]           ymod_reg, ymod_next;
    logic [DAYS_BITS-1:0] days_reg, days_next;
    logic [4:0]           op_day_reg, op_day_next;
    logic [3:0]           op_month_reg, op_month_next;
    logic [YEAR_BITS-1:0] op_year_reg, op_year_next;
    logic [8:0]           mod_reg, mod_next;
    logic [QW-1:0]        quot_reg, quot_next;
    logic                 invalid_reg, invalid_next;
    logic                 earlier_reg, earlier_next;
    logic                 same_reg, same_next;
    logic                 m_valid_reg, m_valid_next;
    cdda_rsp_t            m_data_reg, m_data_next;

    logic [YEAR_BITS-1:0] in_year;
    logic [2*QN:0]        quot_prod;
    logic [YEAR_BITS-1:0] era_base;
    logic                 cur_leap;
    logic [4:0]           cur_dim;
    logic [4:0]           rem_days;
    logic [8:0]           year_len;
    logic [CW-1:0]        days_ext;
    logic                 jan1;
    logic                 era_fits;
    logic                 era_step;
    logic                 year_step;
    logic [CW-1:0]        sub_amt;
    logic [CW-1:0]        days_diff;
    logic [8:0]           ymod_inc;
    logic                 load_ok;
    logic [4:0]           load_dim;

    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    assign in_year   = YEAR_BITS'(s_data.op_year);
    assign quot_prod = (2*QN+1)'(op_year_reg[YEAR_BITS-1:4]) * (2*QN+1)'(QMAG);
    // The quotient times 400 is the sum of its shifts by 8, 7 and 4.
    assign era_base  = {quot_reg, 8'd0} + {1'b0, quot_reg, 7'd0} + {4'd0, quot_reg, 4'd0};
    assign cur_leap  = is_leap(ymod_reg);
    assign cur_dim   = days_in(month_reg, cur_leap);
    assign rem_days  = cur_dim - day_reg;
    assign year_len  = cur_leap ? 9'd366 : 9'd365;
    assign days_ext  = CW'(days_reg);
    assign jan1      = (day_reg == 5'd1) && (month_reg == 4'd1);
    assign era_fits  = ({1'b0, year_reg} + (YEAR_BITS+1)'(YEARS_PER_ERA))
                       <= {1'b0, YMAX};
    assign era_step  = jan1 && era_fits && (days_ext >= CW'(DAYS_PER_400Y));
    assign year_step = jan1 && !era_step && (days_ext >= CW'(year_len));
    assign sub_amt   = era_step  ? CW'(DAYS_PER_400Y) :
                       year_step ? CW'(year_len) : CW'(rem_days) + CW'(1);
    assign days_diff = days_ext - sub_amt;
    assign ymod_inc  = (ymod_reg == YEARS_PER_ERA - 9'd1) ? 9'd0 : ymod_reg + 9'd1;
    assign load_dim  = days_in(op_month_reg, is_leap(mod_reg));
    assign load_ok   = (op_month_reg >= 4'd1) && (op_month_reg <= LAST_MONTH)
                       && (op_day_reg >= 5'd1) && (op_day_reg <= load_dim);

    always_comb begin
        state_next    = state_reg;
        day_next      = day_reg;
        month_next    = month_reg;
        year_next     = year_reg;
        ymod_next     = ymod_reg;
        days_next     = days_reg;
        op_day_next   = op_day_reg;
        op_month_next = op_month_reg;
        op_year_next  = op_year_reg;
        mod_next      = mod_reg;
        quot_next     = quot_reg;
        invalid_next  = invalid_reg;
        earlier_next  = earlier_reg;
        same_next     = same_reg;
        m_valid_next  = m_valid_reg && !m_ready;
        m_data_next   = m_data_reg;

        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    op_day_next   = s_data.op_day;
                    op_month_next = s_data.op_month;
                    op_year_next  = in_year;
                    days_next     = DAYS_BITS'(s_data.add_days);
                    invalid_next  = 1'b0;
                    earlier_next  = 1'b0;
                    same_next     = 1'b0;
                    state_next    = ST_DONE;
                    if (s_data.cmd == CMD_LOAD) begin
                        state_next = ST_MOD;
                    end else if (s_data.cmd == CMD_ADD) begin
                        state_next = ST_ADD;
                    end else if (s_data.cmd == CMD_COMPARE) begin
                        if (year_reg != in_year) begin
                            earlier_next = year_reg < in_year;
                        end else if (month_reg != s_data.op_month) begin
                            earlier_next = month_reg < s_data.op_month;
                        end else begin
                            earlier_next = day_reg < s_data.op_day;
                        end
                        same_next = (day_reg == s_data.op_day)
                                    && (month_reg == s_data.op_month)
                                    && (year_reg == in_year);
                    end
                end
            end
            ST_MOD: begin
                quot_next  = quot_prod[2*QN:QS];
                state_next = ST_REM;
            end
            ST_REM: begin
                mod_next   = 9'(op_year_reg - era_base);
                state_next = ST_LOAD;
            end
            ST_LOAD: begin
                if (load_ok) begin
                    day_next   = op_day_reg;
                    month_next = op_month_reg;
                    year_next  = op_year_reg;
                    ymod_next  = mod_reg;
                end else begin
                    invalid_next = 1'b1;
                end
                state_next = ST_DONE;
            end
            ST_ADD: begin
                if (days_reg == '0) begin
                    state_next = ST_DONE;
                end else if (era_step) begin
                    days_next = DAYS_BITS'(days_diff);
                    year_next = year_reg + YEAR_BITS'(YEARS_PER_ERA);
                end else if (year_step) begin
                    if (year_reg == YMAX) begin
                        day_next     = 5'd31;
                        month_next   = LAST_MONTH;
                        invalid_next = 1'b1;
                        state_next   = ST_DONE;
                    end else begin
                        days_next = DAYS_BITS'(days_diff);
                        year_next = year_reg + YEAR_BITS'(1);
                        ymod_next = ymod_inc;
                    end
                end else if (days_ext <= CW'(rem_days)) begin
                    day_next   = day_reg + 5'(days_reg);
                    state_next = ST_DONE;
                end else begin
                    days_next = DAYS_BITS'(days_diff);
                    day_next  = 5'd1;
                    if (month_reg == LAST_MONTH) begin
                        if (year_reg == YMAX) begin
                            day_next     = 5'd31;
                            invalid_next = 1'b1;
                            state_next   = ST_DONE;
                        end else begin
                            month_next = 4'd1;
                            year_next  = year_reg + YEAR_BITS'(1);
                            ymod_next  = ymod_inc;
                        end
                    end else begin
                        month_next = month_reg + 4'd1;
                    end
                end
            end
            ST_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next          = 1'b1;
                    m_data_next.cur_day   = day_reg;
                    m_data_next.cur_month = month_reg;
                    m_data_next.cur_year  = 16'(year_reg);
                    m_data_next.invalid   = invalid_reg;
                    m_data_next.earlier   = earlier_reg;
                    m_data_next.same      = same_reg;
                    state_next            = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            day_reg     <= 5'd1;
            month_reg   <= 4'd1;
            year_reg    <= YEAR_BITS'(2000);
            ymod_reg    <= 9'd0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            day_reg     <= day_next;
            month_reg   <= month_next;
            year_reg    <= year_next;
            ymod_reg    <= ymod_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        days_reg     <= days_next;
        op_day_reg   <= op_day_next;
        op_month_reg <= op_month_next;
        op_year_reg  <= op_year_next;
        mod_reg      <= mod_next;
        quot_reg     <= quot_next;
        invalid_reg  <= invalid_next;
        earlier_reg  <= earlier_next;
        same_reg     <= same_next;
        m_data_reg   <= m_data_next;
    end

    // The stored month always stays within the calendar.
    a_month_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (month_reg >= 4'd1) && (month_reg <= LAST_MONTH))
        else $error("stored month out of range");

    // The stored day never exceeds the length of the stored month.
    a_day_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (day_reg >= 5'd1) && (day_reg <= cur_dim))
        else $error("stored day out of range");

    // A rejected load leaves the stored date untouched.
    a_bad_load: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_LOAD && !load_ok) |=>
        ($stable(day_reg) && $stable(month_reg) && $stable(year_reg)))
        else $error("rejected load changed the date");

    // Only one request is in work at a time.
    a_one_req: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("second request accepted while busy");

endmodule

FILE: test/tb_top.sv
`timescale 1ns / 1ps
// Testbench for calendar_date_day_adder_top: a table of directed requests followed by
// random requests, results checked against table entries or a model of the date register.
// Depends on cdda_pkg and the top-level RTL.
module tb_top;
    import cdda_pkg::*;

    localparam logic [1:0] CMD_UNUSED = 2'd3;
    localparam int YEAR_MAX = (1 << YEAR_BITS_DEF) - 1;
    localparam int DAYS_PER_ERA = 146097;
    localparam int RANDOM_REQS = 250;

    typedef struct {
        cdda_req_t req;
        bit        typed;
        cdda_rsp_t rsp;
    } date_row_t;

    logic      aclk = 1'b0;
    logic      aresetn = 1'b0;
    logic      s_valid = 1'b0;
    logic      s_ready;
    cdda_req_t s_data = '0;
    logic      m_valid;
    logic      m_ready = 1'b0;
    cdda_rsp_t m_data;

    int        cal_day = 1;
    int        cal_month = 1;
    int        cal_year = 2000;
    cdda_rsp_t expected_dates[$];
    date_row_t directed_rows[$];
    int        errors = 0;
    bit        idle_on = 1'b1;
    int        stall_left = 0;

    calendar_date_day_adder_top uut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    initial begin
        forever #1 aclk = ~aclk;
    end

    initial begin
        #10_000_000;
        $display("calendar_date_day_adder_top test failed");
        $finish;
    end

    function automatic bit leap_year(int y);
        return (y % 4 == 0 && y % 100 != 0) || y % 400 == 0;
    endfunction

    function automatic int month_length(int m, int y);
        case (m)
            2: return leap_year(y) ? 29 : 28;
            4, 6, 9, 11: return 30;
            default: return 31;
        endcase
    endfunction

    function automatic bit advance_by_days(int n);
        int step;
        bit over;
        over = 1'b0;
        while (n > 0 && !over) begin
            if (cal_day == 1 && cal_month == 1 && n >= DAYS_PER_ERA
                    && cal_year + 400 <= YEAR_MAX) begin
                n -= DAYS_PER_ERA;
                cal_year += 400;
            end else if (cal_day == 1 && cal_month == 1
                    && n >= (leap_year(cal_year) ? 366 : 365)) begin
                if (cal_year >= YEAR_MAX) begin
                    over = 1'b1;
                end else begin
                    n -= leap_year(cal_year) ? 366 : 365;
                    cal_year++;
                end
            end else begin
                step = month_length(cal_month, cal_year) - cal_day;
                if (n <= step) begin
                    cal_day += n;
                    n = 0;
                end else begin
                    n -= step + 1;
                    cal_day = 1;
                    cal_month++;
                    if (cal_month > 12) begin
                        if (cal_year >= YEAR_MAX) begin
                            over = 1'b1;
                        end else begin
                            cal_month = 1;
                            cal_year++;
                        end
                    end
                end
            end
        end
        if (over) begin
            cal_day = 31;
            cal_month = 12;
            cal_year = YEAR_MAX;
        end
        return over;
    endfunction

    function automatic cdda_rsp_t apply_request(cdda_req_t r);
        cdda_rsp_t res;
        res = '0;
        case (r.cmd)
            CMD_LOAD: begin
                if (r.op_month >= 1 && r.op_month <= 12 && r.op_day >= 1
                        && r.op_day <= month_length(r.op_month, r.op_year)) begin
                    cal_day = r.op_day;
                    cal_month = r.op_month;
                    cal_year = r.op_year;
                end else begin
                    res.invalid = 1'b1;
                end
            end
            CMD_ADD: begin
                res.invalid = advance_by_days(r.add_days);
            end
            CMD_COMPARE: begin
                if (cal_year != r.op_year) begin
                    res.earlier = cal_year < r.op_year;
                end else if (cal_month != r.op_month) begin
                    res.earlier = cal_month < r.op_month;
                end else begin
                    res.earlier = cal_day < r.op_day;
                end
                res.same = cal_day == r.op_day && cal_month == r.op_month
                           && cal_year == r.op_year;
            end
            default: begin
            end
        endcase
        res.cur_day = 5'(cal_day);
        res.cur_month = 4'(cal_month);
        res.cur_year = 16'(cal_year);
        return res;
    endfunction

    function automatic cdda_req_t request_of(logic [1:0] c, int d, int m, int y, int n);
        cdda_req_t r;
        r.cmd = c;
        r.op_day = 5'(d);
        r.op_month = 4'(m);
        r.op_year = 16'(y);
        r.add_days = 16'(n);
        return r;
    endfunction

    function automatic cdda_rsp_t result_of(int d, int m, int y, bit inv, bit ear, bit sm);
        cdda_rsp_t e;
        e.cur_day = 5'(d);
        e.cur_month = 4'(m);
        e.cur_year = 16'(y);
        e.invalid = inv;
        e.earlier = ear;
        e.same = sm;
        return e;
    endfunction

    function automatic void push_row(cdda_req_t q, bit typed, cdda_rsp_t e);
        date_row_t row;
        row.req = q;
        row.typed = typed;
        row.rsp = e;
        directed_rows.push_back(row);
    endfunction

    function automatic cdda_req_t random_req();
        cdda_req_t r;
        int k;
        int y;
        int m;
        k = $urandom_range(0, 99);
        r = request_of(CMD_UNUSED, $urandom, $urandom, $urandom, $urandom);
        if (k < 36) begin
            r.cmd = CMD_LOAD;
            if (k < 30) begin
                k = $urandom_range(0, 9);
                if (k < 6) begin
                    y = $urandom_range(1580, 2420);
                end else if (k < 9) begin
                    y = $urandom_range(YEAR_MAX - 40, YEAR_MAX);
                end else begin
                    y = $urandom_range(0, YEAR_MAX);
                end
                m = $urandom_range(1, 12);
                r.op_year = 16'(y);
                r.op_month = 4'(m);
                r.op_day = 5'($urandom_range(1, month_length(m, y)));
            end
        end else if (k < 72) begin
            r.cmd = CMD_ADD;
            k = $urandom_range(0, 9);
            if (k < 5) begin
                r.add_days = 16'($urandom_range(0, 40));
            end else if (k < 8) begin
                r.add_days = 16'($urandom_range(0, 1000));
            end
        end else if (k < 95) begin
            r.cmd = CMD_COMPARE;
            k = $urandom_range(0, 2);
            if (k < 2) begin
                r.op_day = 5'(cal_day);
                r.op_month = 4'(cal_month);
                r.op_year = 16'(cal_year);
                if (k == 1) begin
                    case ($urandom_range(0, 2))
                        0: r.op_day = r.op_day + 5'($urandom_range(0, 2)) - 5'd1;
                        1: r.op_month = r.op_month + 4'($urandom_range(0, 2)) - 4'd1;
                        default: r.op_year = r.op_year + 16'($urandom_range(0, 2)) - 16'd1;
                    endcase
                end
            end
        end
        return r;
    endfunction

    function automatic void check_result(cdda_rsp_t got);
        cdda_rsp_t want;
        if (expected_dates.size() == 0) begin
            $error("unexpected result: date %0d/%0d/%0d", got.cur_day, got.cur_month,
                   got.cur_year);
            errors++;
            return;
        end
        want = expected_dates.pop_front();
        if (got.cur_day !== want.cur_day) begin
            $error("cur_day: expected %0d, actual %0d", want.cur_day, got.cur_day);
            errors++;
        end
        if (got.cur_month !== want.cur_month) begin
            $error("cur_month: expected %0d, actual %0d", want.cur_month, got.cur_month);
            errors++;
        end
        if (got.cur_year !== want.cur_year) begin
            $error("cur_year: expected %0d, actual %0d", want.cur_year, got.cur_year);
            errors++;
        end
        if (got.invalid !== want.invalid) begin
            $error("invalid: expected %0d, actual %0d", want.invalid, got.invalid);
            errors++;
        end
        if (got.earlier !== want.earlier) begin
            $error("earlier: expected %0d, actual %0d", want.earlier, got.earlier);
            errors++;
        end
        if (got.same !== want.same) begin
            $error("same: expected %0d, actual %0d", want.same, got.same);
            errors++;
        end
    endfunction

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            check_result(m_data);
        end
        if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            m_ready <= 1'b0;
        end else if (idle_on && $urandom_range(0, 5) == 0) begin
            stall_left <= $urandom_range(0, 16);
            m_ready <= 1'b0;
        end else begin
            m_ready <= 1'b1;
        end
    end

    task automatic send_req(cdda_req_t r, bit typed, cdda_rsp_t typed_rsp);
        cdda_rsp_t predicted;
        if (idle_on && $urandom_range(0, 3) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data <= r;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        predicted = apply_request(r);
        expected_dates.push_back(typed ? typed_rsp : predicted);
    endtask

    task automatic wait_drained();
        s_valid <= 1'b0;
        while (expected_dates.size() != 0) @(posedge aclk);
    endtask

    initial begin
        int i;
        push_row(request_of(CMD_COMPARE, 1, 1, 2000, 0), 1, result_of(1, 1, 2000, 0, 0, 1));
        push_row(request_of(CMD_UNUSED, 31, 15, 65535, 65535), 1,
                 result_of(1, 1, 2000, 0, 0, 0));
        push_row(request_of(CMD_LOAD, 0, 1, 2000, 0), 1, result_of(1, 1, 2000, 1, 0, 0));
        push_row(request_of(CMD_LOAD, 1, 0, 2000, 0), 1, result_of(1, 1, 2000, 1, 0, 0));
        push_row(request_of(CMD_LOAD, 1, 13, 2000, 0), 1, result_of(1, 1, 2000, 1, 0, 0));
        push_row(request_of(CMD_LOAD, 31, 15, 65535, 65535), 1,
                 result_of(1, 1, 2000, 1, 0, 0));
        push_row(request_of(CMD_LOAD, 29, 2, 1900, 0), 1, result_of(1, 1, 2000, 1, 0, 0));
        push_row(request_of(CMD_LOAD, 29, 2, 2000, 0), 1, result_of(29, 2, 2000, 0, 0, 0));
        push_row(request_of(CMD_ADD, 0, 0, 0, 1), 0, '0);
        push_row(request_of(CMD_LOAD, 31, 4, 2021, 0), 1, result_of(1, 3, 2000, 1, 0, 0));
        push_row(request_of(CMD_LOAD, 29, 2, 2024, 0), 0, '0);
        push_row(request_of(CMD_ADD, 0, 0, 0, 0), 0, '0);
        push_row(request_of(CMD_COMPARE, 29, 2, 2024, 0), 1, result_of(29, 2, 2024, 0, 0, 1));
        push_row(request_of(CMD_LOAD, 1, 1, 0, 0), 1, result_of(1, 1, 0, 0, 0, 0));
        push_row(request_of(CMD_ADD, 0, 0, 0, 65535), 0, '0);
        push_row(request_of(CMD_COMPARE, 0, 0, 0, 0), 0, '0);
        push_row(request_of(CMD_LOAD, 31, 12, 65535, 0), 1,
                 result_of(31, 12, 65535, 0, 0, 0));
        push_row(request_of(CMD_ADD, 0, 0, 0, 1), 1, result_of(31, 12, 65535, 1, 0, 0));
        push_row(request_of(CMD_COMPARE, 31, 15, 65535, 0), 0, '0);
        push_row(request_of(CMD_LOAD, 1, 12, 65535, 0), 0, '0);
        push_row(request_of(CMD_ADD, 0, 0, 0, 30), 0, '0);
        push_row(request_of(CMD_LOAD, 1, 12, 65535, 0), 0, '0);
        push_row(request_of(CMD_ADD, 0, 0, 0, 31), 1, result_of(31, 12, 65535, 1, 0, 0));
        push_row(request_of(CMD_LOAD, 1, 1, 65535, 0), 0, '0);
        push_row(request_of(CMD_ADD, 0, 0, 0, 365), 1, result_of(31, 12, 65535, 1, 0, 0));
        push_row(request_of(CMD_LOAD, 28, 2, 2100, 0), 0, '0);
        push_row(request_of(CMD_ADD, 0, 0, 0, 1), 0, '0);

        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;

        foreach (directed_rows[j]) begin
            send_req(directed_rows[j].req, directed_rows[j].typed, directed_rows[j].rsp);
        end
        for (i = 0; i < RANDOM_REQS; i++) begin
            idle_on = (i < 200) && ((i / 40) % 3 != 2);
            if (i == 100) begin
                wait_drained();
            end
            send_req(random_req(), 1'b0, '0);
        end
        wait_drained();
        repeat (40) @(posedge aclk);

        if (errors == 0) begin
            $display("calendar_date_day_adder_top test passed");
        end else begin
            $display("calendar_date_day_adder_top test failed");
        end
        $finish;
    end

endmodule
